>>> hw/rtl/glec_pkg.sv
package glec_pkg;

	// Grid geometry
	localparam int unsigned GLEC_MAX_DIM = 128;
	localparam int unsigned GLEC_IDX_W   = $clog2(GLEC_MAX_DIM);
	localparam int unsigned GLEC_ADDR_W  = 2 * GLEC_IDX_W;
	localparam int unsigned GLEC_DATA_W  = 32;
	localparam int unsigned GLEC_CNT_W   = 8;
	localparam int unsigned GLEC_STEP_W  = 4;

	localparam logic [GLEC_CNT_W-1:0] GLEC_DIM_CAP = GLEC_CNT_W'(GLEC_MAX_DIM);
	localparam logic [GLEC_STEP_W-1:0] GLEC_LAST_STEP = GLEC_STEP_W'(8);

	// Item opcodes
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	// Configuration register indexes
	typedef enum logic {
		CFG_ROW_COUNT    = 1'b0,
		CFG_COLUMN_COUNT = 1'b1
	} cfg_index_t;

	// One request on the grid memory port
	typedef struct packed {
		logic                   we;
		logic                   re;
		logic [GLEC_ADDR_W-1:0] addr;
		logic [GLEC_DATA_W-1:0] wdata;
	} mem_req_t;

	// Finished query result handed to the output register
	typedef struct packed {
		logic valid;
		logic is_extremum;
		logic bad_position;
	} res_t;

	// Row/column offset pair, each in -1..1
	typedef struct packed {
		logic [1:0] dr;
		logic [1:0] dc;
	} offset_t;

	// Visit order: step 0 is the center cell, steps 1..8 its neighbors
	function automatic offset_t glec_offset(input logic [GLEC_STEP_W-1:0] step);
		offset_t o;
		case (step)
			4'd1:    o = '{dr: 2'b11, dc: 2'b11};
			4'd2:    o = '{dr: 2'b11, dc: 2'b00};
			4'd3:    o = '{dr: 2'b11, dc: 2'b01};
			4'd4:    o = '{dr: 2'b00, dc: 2'b11};
			4'd5:    o = '{dr: 2'b00, dc: 2'b01};
			4'd6:    o = '{dr: 2'b01, dc: 2'b11};
			4'd7:    o = '{dr: 2'b01, dc: 2'b00};
			4'd8:    o = '{dr: 2'b01, dc: 2'b01};
			default: o = '{dr: 2'b00, dc: 2'b00};
		endcase
		return o;
	endfunction

endpackage

>>> hw/rtl/glec_grid_ram.sv
module glec_grid_ram (
	input  logic                           clk,
	input  glec_pkg::mem_req_t             req,
	output logic [glec_pkg::GLEC_DATA_W-1:0] rdata
);
	import glec_pkg::*;

	localparam int unsigned Depth = 1 << GLEC_ADDR_W;

	logic [GLEC_DATA_W-1:0] mem [Depth];
	logic [GLEC_DATA_W-1:0] rdata_q;

	// Single port, registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/glec_ctrl.sv
module glec_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             opcode,
	input  logic [glec_pkg::GLEC_IDX_W-1:0]  row,
	input  logic [glec_pkg::GLEC_IDX_W-1:0]  column,
	input  logic [glec_pkg::GLEC_DATA_W-1:0] cell_value,
	input  logic [glec_pkg::GLEC_CNT_W-1:0]  rows_eff,
	input  logic [glec_pkg::GLEC_CNT_W-1:0]  cols_eff,
	output glec_pkg::mem_req_t               mem_req,
	input  logic [glec_pkg::GLEC_DATA_W-1:0] mem_rdata,
	output glec_pkg::res_t                   res,
	input  logic                             res_ready
);
	import glec_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic [GLEC_STEP_W-1:0]   step_q;
	logic [GLEC_IDX_W-1:0]    row_q;
	logic [GLEC_IDX_W-1:0]    col_q;
	logic                     above_q;
	logic                     below_q;
	logic                     bad_q;
	logic signed [GLEC_DATA_W-1:0] centre_q;

	// Read pipeline: data for the read issued last cycle arrives now
	logic chk_s1;
	logic use_s1;
	logic centre_s1;

	logic                  accept;
	logic                  in_grid;
	offset_t               off;
	logic [GLEC_CNT_W-1:0] nr;
	logic [GLEC_CNT_W-1:0] nc;
	logic                  nb_in;
	logic signed [GLEC_DATA_W-1:0] other;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_grid  = ({1'b0, row} < rows_eff) && ({1'b0, column} < cols_eff);

	// Neighbor position; a step below zero wraps high and fails the bound check
	always_comb begin
		off   = glec_offset(step_q);
		nr    = {1'b0, row_q} + {{(GLEC_CNT_W-2){off.dr[1]}}, off.dr};
		nc    = {1'b0, col_q} + {{(GLEC_CNT_W-2){off.dc[1]}}, off.dc};
		nb_in = (nr < rows_eff) && (nc < cols_eff);
		other = $signed(mem_rdata);
	end

	// Memory port: writes while idle, neighborhood reads while querying
	always_comb begin
		mem_req       = '0;
		mem_req.wdata = cell_value;
		if (state_q == ST_IDLE) begin
			mem_req.we   = accept && (opcode == OP_WRITE) && in_grid;
			mem_req.addr = {row, column};
		end else begin
			mem_req.re   = (state_q == ST_READ);
			mem_req.addr = {nr[GLEC_IDX_W-1:0], nc[GLEC_IDX_W-1:0]};
		end
	end

	assign res.valid        = (state_q == ST_DONE);
	assign res.is_extremum  = above_q || below_q;
	assign res.bad_position = bad_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			row_q     <= '0;
			col_q     <= '0;
			centre_q  <= '0;
			chk_s1    <= 1'b0;
			use_s1    <= 1'b0;
			centre_s1 <= 1'b0;
			above_q   <= 1'b0;
			below_q   <= 1'b0;
			bad_q     <= 1'b0;
		end else begin
			// Compare the beat of read data that just arrived
			if (chk_s1) begin
				if (centre_s1) begin
					centre_q <= other;
				end else if (use_s1) begin
					if (!(centre_q > other)) begin
						above_q <= 1'b0;
					end
					if (!(centre_q < other)) begin
						below_q <= 1'b0;
					end
				end
			end

			case (state_q)
				ST_IDLE: begin
					chk_s1 <= 1'b0;
					if (accept && (opcode == OP_QUERY)) begin
						row_q  <= row;
						col_q  <= column;
						step_q <= '0;
						if (in_grid) begin
							bad_q   <= 1'b0;
							above_q <= 1'b1;
							below_q <= 1'b1;
							state_q <= ST_READ;
						end else begin
							bad_q   <= 1'b1;
							above_q <= 1'b0;
							below_q <= 1'b0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_READ: begin
					chk_s1    <= 1'b1;
					use_s1    <= nb_in;
					centre_s1 <= (step_q == '0);
					if (step_q == GLEC_LAST_STEP) begin
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					chk_s1  <= 1'b0;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					chk_s1 <= 1'b0;
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					chk_s1  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/grid_local_extremum_check_core.sv
// Channel  Direction  Handshake          Beat contents
// in       input      in_valid/in_stall  opcode, row, column, cell_value
// out      output     out_valid/out_stall is_extremum, bad_position
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A write is stored in the grid memory on the beat it is accepted, if it lies inside the grid.
// A query inside the grid runs from the accept through nine reads of the center and its
// neighbors on the single memory port, a drain state for the read latency and a done state
// that hands the result to the output register. A query outside the grid goes to done directly.
// Reset clears control state only; grid cells hold nothing defined until written.
// A stalled result waits in the output register; a second result then waits in the core.
module grid_local_extremum_check_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             opcode,
	input  logic [glec_pkg::GLEC_IDX_W-1:0]  row,
	input  logic [glec_pkg::GLEC_IDX_W-1:0]  column,
	input  logic [glec_pkg::GLEC_DATA_W-1:0] cell_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             is_extremum,
	output logic                             bad_position,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [glec_pkg::GLEC_CNT_W-1:0]  cfg_data
);
	import glec_pkg::*;

	logic [GLEC_CNT_W-1:0]  row_count_q;
	logic [GLEC_CNT_W-1:0]  column_count_q;
	logic [GLEC_CNT_W-1:0]  rows_eff;
	logic [GLEC_CNT_W-1:0]  cols_eff;
	mem_req_t               mem_req;
	logic [GLEC_DATA_W-1:0] mem_rdata;
	res_t                   res;
	logic                   res_ready;
	logic                   out_valid_q;
	logic                   is_extremum_q;
	logic                   bad_position_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= GLEC_DIM_CAP;
			column_count_q <= GLEC_DIM_CAP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_ROW_COUNT:    row_count_q    <= cfg_data;
				CFG_COLUMN_COUNT: column_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Counts above the grid size act as the grid size
	assign rows_eff = (row_count_q > GLEC_DIM_CAP) ? GLEC_DIM_CAP : row_count_q;
	assign cols_eff = (column_count_q > GLEC_DIM_CAP) ? GLEC_DIM_CAP : column_count_q;

	glec_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.row        (row),
		.column     (column),
		.cell_value (cell_value),
		.rows_eff   (rows_eff),
		.cols_eff   (cols_eff),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata),
		.res        (res),
		.res_ready  (res_ready)
	);

	glec_grid_ram u_grid_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// Output register
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			is_extremum_q  <= res.is_extremum;
			bad_position_q <= res.bad_position;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_extremum  = is_extremum_q;
	assign bad_position = bad_position_q;

endmodule
